// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; pulled in by the expression tokenizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/etok_pkg.sv
// Types, character codes and classification helpers for the expression tokenizer.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package etok_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_IDENT = 4'b0010,
        MODE_INT   = 4'b0100,
        MODE_FRAC  = 4'b1000
    } scan_mode_t;

    typedef enum logic [3:0] {
        KIND_IDENT   = 4'd0,
        KIND_NUMBER  = 4'd1,
        KIND_PLUS    = 4'd2,
        KIND_MINUS   = 4'd3,
        KIND_STAR    = 4'd4,
        KIND_SLASH   = 4'd5,
        KIND_LPAREN  = 4'd6,
        KIND_RPAREN  = 4'd7,
        KIND_UNKNOWN = 4'd8,
        KIND_END     = 4'd9
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        overflow;
        logic        last;
    } token_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_US     = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Result queue: one byte can produce two words, the sink drains one.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic token_kind_t op_kind(input logic [7:0] b);
        token_kind_t k;
        case (b)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            default:   k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/etok_ifs.sv
// Valid/ready channel interfaces: source bytes in, token words out.
// Depends on etok_pkg for the token kind type.
`timescale 1ns / 1ps

interface etok_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface etok_tok_if;
    import etok_pkg::*;

    logic        valid;
    logic        ready;
    token_kind_t token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        overflow;
    logic        last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output overflow, output last, input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input overflow, input last, output ready);
endinterface

// File: rtl/expression_tokenizer_top.sv
// Expression tokenizer: streaming lexer for arithmetic expressions.
// Depends on etok_pkg, the channel interfaces in etok_ifs.sv and assert_macros.svh.
//
//   channel | dir | interface   | word carries
//   --------+-----+-------------+------------------------------------------------
//   bytes   | in  | etok_byte_if| in_byte: one source character, 0 ends string
//   tokens  | out | etok_tok_if | token_kind, token_start, token_length,
//           |     |             | overflow, last
//
// One byte is taken per cycle; its classification and scan-mode update happen
// in the accepting cycle and its zero, one or two token words land in a
// four-deep result queue. Bytes keep flowing while at least two queue slots
// are free, so with an open sink the rate is one byte per clock; the sink
// drains one word per clock, which sets the rate when bytes yield two words.
// Reset clears scan state, position and the queue pointers at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module expression_tokenizer_top #(
    parameter int POS_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    etok_byte_if.sink          bytes,
    etok_tok_if.source         tokens
);
    import etok_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    // Position counter is POS_WIDTH wide; token fields carry its low 16 bits.
    function automatic logic [15:0] pos16(input logic [POS_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    // Scan state
    scan_mode_t           mode_reg, mode_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [POS_WIDTH-1:0] beg_reg, beg_next;
    logic                 ovf_reg, ovf_next;

    // Result queue
    token_t               q_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;

    logic       accept, pop;
    logic [7:0] b;
    logic       b_letter, b_digit, b_us, b_dot, b_zero, b_space;
    logic       cont, consume, end_str, sat;
    logic       pend_hit, fresh_hit;
    token_t     pend_res, fresh_res, slot0, slot1;
    logic [1:0] n_new;

    assign b        = bytes.in_byte;
    assign b_letter = is_letter(b);
    assign b_digit  = is_digit(b);
    assign b_us     = (b == CH_US);
    assign b_dot    = (b == CH_DOT);
    assign b_zero   = (b == CH_NUL);
    assign b_space  = is_space(b);
    assign sat      = (pos_reg == POS_MAX);

    assign bytes.ready = (cnt_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign accept      = bytes.valid && bytes.ready;
    assign pop         = tokens.valid && tokens.ready;

    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        beg_next  = beg_reg;
        ovf_next  = ovf_reg;
        consume   = 1'b0;
        end_str   = 1'b0;
        pend_hit  = 1'b0;
        fresh_hit = 1'b0;
        cont      = 1'b0;

        // Pending token closes with the counter as it stands.
        pend_res.kind     = (mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
        pend_res.start    = pos16(beg_reg);
        pend_res.length   = pos16(pos_reg - beg_reg);
        pend_res.overflow = ovf_reg;
        pend_res.last     = 1'b0;

        fresh_res.kind     = op_kind(b);
        fresh_res.start    = pos16(pos_reg);
        fresh_res.length   = 16'd1;
        fresh_res.overflow = ovf_reg || sat;
        fresh_res.last     = 1'b1;

        unique case (mode_reg)
            MODE_IDENT: cont = b_letter || b_digit || b_us;
            MODE_INT:   cont = b_digit || b_dot;
            MODE_FRAC:  cont = b_digit;
            MODE_IDLE:  cont = 1'b0;
            default:    cont = 1'b0;
        endcase

        if (cont)
        begin
            consume = 1'b1;
            if (mode_reg == MODE_INT && b_dot)
                mode_next = MODE_FRAC;
        end
        else
        begin
            // Close any pending token, then rescan the byte from idle.
            pend_hit  = (mode_reg != MODE_IDLE);
            mode_next = MODE_IDLE;
            priority if (b_zero)
            begin
                fresh_hit          = 1'b1;
                end_str            = 1'b1;
                fresh_res.kind     = KIND_END;
                fresh_res.length   = 16'd0;
                fresh_res.overflow = ovf_reg;
            end
            else if (b_space)
                consume = 1'b1;
            else if (b_letter || b_us)
            begin
                beg_next  = pos_reg;
                mode_next = MODE_IDENT;
                consume   = 1'b1;
            end
            else if (b_digit)
            begin
                beg_next  = pos_reg;
                mode_next = MODE_INT;
                consume   = 1'b1;
            end
            else if (b_dot)
            begin
                beg_next  = pos_reg;
                mode_next = MODE_FRAC;
                consume   = 1'b1;
            end
            else
            begin
                fresh_hit = 1'b1;
                consume   = 1'b1;
            end
        end

        // Advance the position, or hold it at the top and flag overflow.
        if (consume)
        begin
            if (sat)
                ovf_next = 1'b1;
            else
                pos_next = pos_reg + POS_WIDTH'(1);
        end

        // End of string: drop back to the reset state.
        if (end_str)
        begin
            mode_next = MODE_IDLE;
            pos_next  = '0;
            beg_next  = '0;
            ovf_next  = 1'b0;
        end
    end

    // Pack the new words into queue order.
    always_comb
    begin
        slot0      = pend_hit ? pend_res : fresh_res;
        slot0.last = !(pend_hit && fresh_hit);
        slot1      = fresh_res;
        n_new      = accept ? (2'(pend_hit) + 2'(fresh_hit)) : 2'd0;

        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(n_new);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        cnt_next    = cnt_reg + RES_CNT_W'(n_new) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            beg_reg    <= '0;
            ovf_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                beg_reg  <= beg_next;
                ovf_reg  <= ovf_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_new != 2'd0)
            q_reg[wr_ptr_reg] <= slot0;
        if (n_new == 2'd2)
            q_reg[wr_ptr_reg + RES_PTR_W'(1)] <= slot1;
    end

    assign tokens.valid        = (cnt_reg != '0);
    assign tokens.token_kind   = q_reg[rd_ptr_reg].kind;
    assign tokens.token_start  = q_reg[rd_ptr_reg].start;
    assign tokens.token_length = q_reg[rd_ptr_reg].length;
    assign tokens.overflow     = q_reg[rd_ptr_reg].overflow;
    assign tokens.last         = q_reg[rd_ptr_reg].last;

    // Checks
    `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, cnt_reg <= RES_CNT_W'(RES_DEPTH), "result queue overrun")
    `ASSERT_ALWAYS(a_ovf_saturated, clk, rst_n, !ovf_reg || pos_reg == POS_MAX, "overflow without saturated position")
    `ASSERT_NEXT(a_end_restart, clk, rst_n, accept && b_zero, pos_reg == '0 && mode_reg == MODE_IDLE && !ovf_reg, "scan state not restarted after end")

endmodule
